// ===== rtl/core/adaptive_interval_controller_defines.svh =====
// Assertion macros for the adaptive interval controller.
`ifndef ADAPTIVE_INTERVAL_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_INTERVAL_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define AIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("aic assertion failed");
`define AIC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("aic assertion failed");
`else
`define AIC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AIC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/aic_pkg.sv =====
`timescale 1ns / 1ps
package aic_pkg;

	localparam int unsigned MS_W    = 20;
	localparam int unsigned Q16_W   = 17;
	localparam int unsigned SIZE_W  = 32;
	localparam int unsigned BYTES_W = 40;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned OP_W    = 32;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned PROD_W  = 52;
	localparam int unsigned ACC_W   = 68;
	localparam int unsigned NUM_W   = ACC_W - FRAC_W;
	localparam int unsigned DIV_STEPS = NUM_W;
	localparam int unsigned CNT_W   = 6;

	localparam logic [MS_W-1:0]   MS_MAX  = 20'hFFFFF;
	localparam logic [Q16_W-1:0]  ONE_Q16 = 17'h10000;

	localparam logic [MS_W-1:0]   RST_MIN_MS   = 20'd250;
	localparam logic [MS_W-1:0]   RST_MAX_MS   = 20'd10000;
	localparam logic [Q16_W-1:0]  RST_FILL     = 17'd52429;
	localparam logic [Q16_W-1:0]  RST_SPEEDUP  = 17'd58982;
	localparam logic [Q16_W-1:0]  RST_SLOWDOWN = 17'd6554;
	localparam logic [SIZE_W-1:0] RST_OBJ_SIZE = 32'd67108864;

	typedef enum logic [2:0] {
		REG_MIN_INTERVAL = 3'd0,
		REG_MAX_INTERVAL = 3'd1,
		REG_TARGET_FILL  = 3'd2,
		REG_SPEEDUP      = 3'd3,
		REG_SLOWDOWN     = 3'd4,
		REG_OBJ_SIZE     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [MS_W-1:0]   min_interval_ms;
		logic [MS_W-1:0]   max_interval_ms;
		logic [Q16_W-1:0]  target_fill_q16;
		logic [Q16_W-1:0]  speedup_weight_q16;
		logic [Q16_W-1:0]  slowdown_weight_q16;
		logic [SIZE_W-1:0] max_object_size_bytes;
	} cfg_t;

	typedef enum logic [2:0] {
		MUL_CUR_SIZE,
		MUL_P_LO,
		MUL_P_HI,
		MUL_CUR_WINV,
		MUL_IDEAL_W
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_HI,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [1:0] {
		IDEAL_HOLD,
		IDEAL_MAX,
		IDEAL_DIV
	} ideal_op_t;

	typedef struct packed {
		logic      load_in;
		mul_sel_t  mul_sel;
		logic      load_p;
		acc_op_t   acc_op;
		logic      div_init;
		logic      div_step;
		ideal_op_t ideal_op;
		logic      commit;
	} dp_cmd_t;

	typedef struct packed {
		logic bytes_zero;
		logic div_last;
	} dp_stat_t;

	function automatic logic [Q16_W-1:0] sat_q16(input logic [Q16_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

endpackage

// ===== rtl/core/aic_channels.sv =====
`timescale 1ns / 1ps
interface aic_in_if;
	logic                         valid;
	logic                         ready;
	logic [aic_pkg::BYTES_W-1:0]  bytes_produced;

	modport source (output valid, output bytes_produced, input ready);
	modport sink (input valid, input bytes_produced, output ready);
endinterface

interface aic_out_if;
	logic                      valid;
	logic                      ready;
	logic [aic_pkg::MS_W-1:0]  interval_ms;

	modport source (output valid, output interval_ms, input ready);
	modport sink (input valid, input interval_ms, output ready);
endinterface

// ===== rtl/core/aic_regs.sv =====
`timescale 1ns / 1ps
module aic_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aic_pkg::ADDR_W-1:0]  paddr,
	input  logic [aic_pkg::DATA_W-1:0]  pwdata,
	output logic [aic_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output aic_pkg::cfg_t               cfg
);
	import aic_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval_ms       <= RST_MIN_MS;
			cfg_q.max_interval_ms       <= RST_MAX_MS;
			cfg_q.target_fill_q16       <= RST_FILL;
			cfg_q.speedup_weight_q16    <= RST_SPEEDUP;
			cfg_q.slowdown_weight_q16   <= RST_SLOWDOWN;
			cfg_q.max_object_size_bytes <= RST_OBJ_SIZE;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_INTERVAL: cfg_q.min_interval_ms <= pwdata[MS_W-1:0];
				REG_MAX_INTERVAL: cfg_q.max_interval_ms <= pwdata[MS_W-1:0];
				REG_TARGET_FILL:  cfg_q.target_fill_q16 <= pwdata[Q16_W-1:0];
				REG_SPEEDUP:      cfg_q.speedup_weight_q16 <= pwdata[Q16_W-1:0];
				REG_SLOWDOWN:     cfg_q.slowdown_weight_q16 <= pwdata[Q16_W-1:0];
				REG_OBJ_SIZE:     cfg_q.max_object_size_bytes <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_INTERVAL: prdata = DATA_W'(cfg_q.min_interval_ms);
			REG_MAX_INTERVAL: prdata = DATA_W'(cfg_q.max_interval_ms);
			REG_TARGET_FILL:  prdata = DATA_W'(cfg_q.target_fill_q16);
			REG_SPEEDUP:      prdata = DATA_W'(cfg_q.speedup_weight_q16);
			REG_SLOWDOWN:     prdata = DATA_W'(cfg_q.slowdown_weight_q16);
			REG_OBJ_SIZE:     prdata = DATA_W'(cfg_q.max_object_size_bytes);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/aic_dp.sv =====
`timescale 1ns / 1ps
module aic_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  aic_pkg::dp_cmd_t             cmd,
	output aic_pkg::dp_stat_t            stat,
	input  aic_pkg::cfg_t                cfg,
	input  logic [aic_pkg::BYTES_W-1:0]  bytes_produced,
	output logic [aic_pkg::MS_W-1:0]     interval_ms
);
	import aic_pkg::*;

	logic [MS_W-1:0]    current_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [PROD_W-1:0]  mul_q;
	logic [PROD_W-1:0]  p_q;
	logic [ACC_W-1:0]   acc_q;
	logic [NUM_W-1:0]   num_q;
	logic [BYTES_W-1:0] rem_q;
	logic [MS_W-1:0]    quo_q;
	logic               ovf_q;
	logic [MS_W-1:0]    ideal_q;
	logic [MS_W-1:0]    interval_q;

	logic [Q16_W-1:0]   fill_sat;
	logic [Q16_W-1:0]   w;
	logic [Q16_W-1:0]   w_inv;
	logic [OP_W-1:0]    mul_a;
	logic [OP_W-1:0]    mul_b;
	logic [2*OP_W-1:0]  product;
	logic [BYTES_W:0]   trial;
	logic [BYTES_W:0]   diff;
	logic               fits;
	logic [MS_W-1:0]    blended;
	logic [MS_W-1:0]    clamped;

	assign fill_sat = sat_q16(cfg.target_fill_q16);
	assign w = sat_q16((ideal_q < current_q) ? cfg.speedup_weight_q16
		: cfg.slowdown_weight_q16);
	assign w_inv = ONE_Q16 - w;

	always_comb begin
		case (cmd.mul_sel)
			MUL_CUR_SIZE: begin
				mul_a = OP_W'(current_q);
				mul_b = OP_W'(cfg.max_object_size_bytes);
			end
			MUL_P_LO: begin
				mul_a = p_q[OP_W-1:0];
				mul_b = OP_W'(fill_sat);
			end
			MUL_P_HI: begin
				mul_a = OP_W'(p_q[PROD_W-1:OP_W]);
				mul_b = OP_W'(fill_sat);
			end
			MUL_CUR_WINV: begin
				mul_a = OP_W'(current_q);
				mul_b = OP_W'(w_inv);
			end
			MUL_IDEAL_W: begin
				mul_a = OP_W'(ideal_q);
				mul_b = OP_W'(w);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign product = mul_a * mul_b;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, bytes_q};
	assign diff  = trial - {1'b0, bytes_q};

	assign blended = acc_q[FRAC_W +: MS_W];
	always_comb begin
		if (blended < cfg.min_interval_ms) begin
			clamped = cfg.min_interval_ms;
		end else if (blended > cfg.max_interval_ms) begin
			clamped = cfg.max_interval_ms;
		end else begin
			clamped = blended;
		end
	end

	assign stat.bytes_zero = (bytes_q == '0);
	assign stat.div_last   = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign interval_ms     = interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= RST_MIN_MS;
			cnt_q     <= '0;
		end else begin
			if (cmd.commit) begin
				current_q <= clamped;
			end
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= product[PROD_W-1:0];
		if (cmd.load_in) begin
			bytes_q <= bytes_produced;
		end
		if (cmd.load_p) begin
			p_q <= mul_q;
		end
		case (cmd.acc_op)
			ACC_LOAD:   acc_q <= ACC_W'(mul_q);
			ACC_ADD_HI: acc_q <= acc_q + (ACC_W'(mul_q) << OP_W);
			ACC_ADD:    acc_q <= acc_q + ACC_W'(mul_q);
			default:    ;
		endcase
		if (cmd.div_init) begin
			num_q <= acc_q[ACC_W-1:FRAC_W];
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[BYTES_W-1:0] : trial[BYTES_W-1:0];
			quo_q <= {quo_q[MS_W-2:0], fits};
			ovf_q <= ovf_q | quo_q[MS_W-1];
		end
		case (cmd.ideal_op)
			IDEAL_MAX: ideal_q <= cfg.max_interval_ms;
			IDEAL_DIV: ideal_q <= ovf_q ? MS_MAX : quo_q;
			default:   ;
		endcase
		if (cmd.commit) begin
			interval_q <= clamped;
		end
	end

endmodule

// ===== rtl/core/aic_ctrl.sv =====
`timescale 1ns / 1ps
module aic_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  aic_pkg::dp_stat_t  stat,
	output aic_pkg::dp_cmd_t   cmd
);
	import aic_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_M5,
		S_DINIT,
		S_DIV,
		S_IDEAL,
		S_B1,
		S_B2,
		S_B3,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_CUR_SIZE;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_M1;
				end
			end
			S_M1: begin
				if (stat.bytes_zero) begin
					cmd.ideal_op = IDEAL_MAX;
					state_d      = S_B1;
				end else begin
					state_d = S_M2;
				end
			end
			S_M2: begin
				cmd.load_p = 1'b1;
				state_d    = S_M3;
			end
			S_M3: begin
				cmd.mul_sel = MUL_P_LO;
				state_d     = S_M4;
			end
			S_M4: begin
				cmd.mul_sel = MUL_P_HI;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_M5;
			end
			S_M5: begin
				cmd.acc_op = ACC_ADD_HI;
				state_d    = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_IDEAL;
				end
			end
			S_IDEAL: begin
				cmd.ideal_op = IDEAL_DIV;
				state_d      = S_B1;
			end
			S_B1: begin
				cmd.mul_sel = MUL_CUR_WINV;
				state_d     = S_B2;
			end
			S_B2: begin
				cmd.mul_sel = MUL_IDEAL_W;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_B3;
			end
			S_B3: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/adaptive_interval_controller.sv =====
`timescale 1ns / 1ps
// Adaptive interval controller.
// The sample channel carries one item per round: the largest byte count
// produced in that round. The result channel returns one item for each
// sample: the new interval in milliseconds, which also becomes the stored
// current interval used by the next sample.
// A sample with a nonzero count passes through a shared 32 by 32 bit
// multiplier three times, a 52-step restoring divider and two blend
// multiplications. An idle round (count zero) skips the first three
// multiplications and the divider and goes straight to the blend.
// Samples are taken one at a time, so the sustained rate is set by the
// one-bit-per-cycle divider.
// The result sits in an output register: a new sample is accepted while it
// waits, and a finished result is held back until the receiver takes the
// previous one. A stalled receiver therefore stalls the sample channel
// after at most one further item.
// Reset loads the register defaults, sets the current interval to 250 ms
// and empties the output register. The user must write the APB port only
// while the block is idle; the block does not enforce it. pready is always high.
module adaptive_interval_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	aic_in_if.sink                      sample,
	aic_out_if.source                   result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aic_pkg::ADDR_W-1:0]  paddr,
	input  logic [aic_pkg::DATA_W-1:0]  pwdata,
	output logic [aic_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import aic_pkg::*;
	`include "adaptive_interval_controller_defines.svh"

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     bounds_ordered;
	logic     result_in_range;

	aic_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	aic_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg            (cfg),
		.bytes_produced (sample.bytes_produced),
		.interval_ms    (result.interval_ms)
	);

	assign bounds_ordered  = (cfg.min_interval_ms <= cfg.max_interval_ms);
	assign result_in_range = (result.interval_ms >= cfg.min_interval_ms)
		&& (result.interval_ms <= cfg.max_interval_ms);

	`AIC_ASSERT_IMP(a_accept_loads, clk, arst_n, sample.valid && sample.ready, cmd.load_in)
	`AIC_ASSERT_NXT(a_busy_after_accept, clk, arst_n, sample.valid && sample.ready, !sample.ready)
	`AIC_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.commit && result.valid, result.ready)
	`AIC_ASSERT_IMP(a_result_in_bounds, clk, arst_n, result.valid && bounds_ordered, result_in_range)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import aic_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	aic_in_if sample_ch();
	aic_out_if result_ch();

	cfg_t model_cfg;
	logic [MS_W-1:0] model_current;
	logic [MS_W-1:0] pending_intervals[$];
	int errors = 0;
	int idle_pct = 20;

	adaptive_interval_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [MS_W-1:0] next_interval(input logic [MS_W-1:0] cur,
			input cfg_t c, input logic [BYTES_W-1:0] count);
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] quo;
		logic [MS_W-1:0] ideal;
		logic [Q16_W-1:0] fill;
		logic [Q16_W-1:0] w;
		logic [63:0] mix;
		fill = (c.target_fill_q16 > ONE_Q16) ? ONE_Q16 : c.target_fill_q16;
		if (count == '0) begin
			ideal = c.max_interval_ms;
		end else begin
			num = 128'(cur) * 128'(c.max_object_size_bytes) * 128'(fill);
			den = 128'(count) << FRAC_W;
			quo = num / den;
			ideal = (quo > 128'(MS_MAX)) ? MS_MAX : quo[MS_W-1:0];
		end
		w = (ideal < cur) ? c.speedup_weight_q16 : c.slowdown_weight_q16;
		if (w > ONE_Q16)
			w = ONE_Q16;
		mix = (64'(ONE_Q16) - 64'(w)) * 64'(cur) + 64'(w) * 64'(ideal);
		mix = mix >> FRAC_W;
		if (mix < 64'(c.min_interval_ms))
			return c.min_interval_ms;
		if (mix > 64'(c.max_interval_ms))
			return c.max_interval_ms;
		return mix[MS_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(input reg_idx_t idx);
		case (idx)
			REG_MIN_INTERVAL: return DATA_W'(model_cfg.min_interval_ms);
			REG_MAX_INTERVAL: return DATA_W'(model_cfg.max_interval_ms);
			REG_TARGET_FILL:  return DATA_W'(model_cfg.target_fill_q16);
			REG_SPEEDUP:      return DATA_W'(model_cfg.speedup_weight_q16);
			REG_SLOWDOWN:     return DATA_W'(model_cfg.slowdown_weight_q16);
			REG_OBJ_SIZE:     return DATA_W'(model_cfg.max_object_size_bytes);
			default:          return '0;
		endcase
	endfunction

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_intervals.size() == 0) begin
				$display("%0t: interval_ms expected none, actual %0d", $time,
					result_ch.interval_ms);
				errors++;
			end else begin
				if (result_ch.interval_ms !== pending_intervals[0]) begin
					$display("%0t: interval_ms expected %0d, actual %0d", $time,
						pending_intervals[0], result_ch.interval_ms);
					errors++;
				end
				void'(pending_intervals.pop_front());
			end
		end
	end

	task automatic send_count(input logic [BYTES_W-1:0] count);
		while ($urandom_range(99) < idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.bytes_produced <= count;
		do
			@(posedge clk);
		while (!(sample_ch.valid && sample_ch.ready));
		model_current = next_interval(model_current, model_cfg, count);
		pending_intervals.push_back(model_current);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (pending_intervals.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input reg_idx_t idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(input reg_idx_t idx);
		logic [DATA_W-1:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd !== reg_value(idx)) begin
			$display("%0t: register %s expected %0d, actual %0d", $time, idx.name(),
				reg_value(idx), rd);
			errors++;
		end
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] rd;
		wait_idle();
		apb_access(1'b1, idx, val, rd);
		case (idx)
			REG_MIN_INTERVAL: model_cfg.min_interval_ms = val[MS_W-1:0];
			REG_MAX_INTERVAL: model_cfg.max_interval_ms = val[MS_W-1:0];
			REG_TARGET_FILL:  model_cfg.target_fill_q16 = val[Q16_W-1:0];
			REG_SPEEDUP:      model_cfg.speedup_weight_q16 = val[Q16_W-1:0];
			REG_SLOWDOWN:     model_cfg.slowdown_weight_q16 = val[Q16_W-1:0];
			REG_OBJ_SIZE:     model_cfg.max_object_size_bytes = val[SIZE_W-1:0];
			default: ;
		endcase
		check_reg(idx);
	endtask

	function automatic logic [BYTES_W-1:0] random_count();
		logic [BYTES_W-1:0] full;
		int unsigned pick;
		pick = $urandom_range(99);
		full = {8'($urandom_range(255)), $urandom};
		if (pick < 10)
			return '0;
		if (pick < 35)
			return full;
		return full >> $urandom_range(BYTES_W - 1);
	endfunction

	function automatic logic [DATA_W-1:0] random_q16();
		case ($urandom_range(9))
			0: return '0;
			1: return DATA_W'(ONE_Q16);
			2: return $urandom_range(131071, 65537);
			default: return $urandom_range(65536);
		endcase
	endfunction

	task automatic test_reset_defaults();
		reg_idx_t idx;
		idx = idx.first();
		repeat (idx.num()) begin
			check_reg(idx);
			idx = idx.next();
		end
		send_count('0);
		send_count(40'd1);
		send_count(40'hFF_FFFF_FFFF);
		send_count(40'd52428800);
		send_count(40'h55_5555_5555);
		send_count(40'hAA_AAAA_AAAA);
		send_count('0);
		send_count(40'd1000);
	endtask

	task automatic test_weight_and_fill_limits();
		set_reg(REG_SPEEDUP, '0);
		set_reg(REG_SLOWDOWN, DATA_W'(ONE_Q16));
		send_count(40'd1);
		send_count(40'hFF_FFFF_FFFF);
		send_count('0);
		set_reg(REG_SPEEDUP, 32'd131071);
		set_reg(REG_SLOWDOWN, 32'd65537);
		set_reg(REG_TARGET_FILL, 32'd131071);
		send_count(40'd1 << 20);
		send_count('0);
		send_count(40'd3);
		set_reg(REG_TARGET_FILL, '0);
		send_count(40'd7);
	endtask

	task automatic test_zero_object_size();
		set_reg(REG_TARGET_FILL, DATA_W'(RST_FILL));
		set_reg(REG_OBJ_SIZE, '0);
		send_count(40'd1);
		send_count('0);
		send_count(40'h80_0000_0000);
	endtask

	task automatic test_clamp_bounds();
		set_reg(REG_OBJ_SIZE, 32'hFFFF_FFFF);
		set_reg(REG_MIN_INTERVAL, 32'd5000);
		set_reg(REG_MAX_INTERVAL, 32'd100);
		send_count('0);
		send_count(40'd1);
		send_count(40'd9);
		set_reg(REG_MIN_INTERVAL, '0);
		set_reg(REG_MAX_INTERVAL, DATA_W'(MS_MAX));
		send_count(40'd1);
		send_count('0);
		send_count(40'hFF_FFFF_FFFF);
	endtask

	task automatic test_random_rounds();
		logic [DATA_W-1:0] lo_bound;
		logic [DATA_W-1:0] hi_bound;
		logic [DATA_W-1:0] obj_size;
		for (int phase = 0; phase < 19; phase++) begin
			case ($urandom_range(9))
				0: lo_bound = '0;
				1: lo_bound = DATA_W'(MS_MAX);
				default: lo_bound = $urandom_range(5000);
			endcase
			case ($urandom_range(9))
				0: hi_bound = DATA_W'(MS_MAX);
				1: hi_bound = '0;
				default: hi_bound = $urandom_range(200000, 1000);
			endcase
			case ($urandom_range(9))
				0: obj_size = 32'd1;
				1: obj_size = 32'hFFFF_FFFF;
				2: obj_size = '0;
				default: obj_size = $urandom >> $urandom_range(20);
			endcase
			set_reg(REG_MIN_INTERVAL, lo_bound);
			set_reg(REG_MAX_INTERVAL, hi_bound);
			set_reg(REG_TARGET_FILL, random_q16());
			set_reg(REG_SPEEDUP, random_q16());
			set_reg(REG_SLOWDOWN, random_q16());
			set_reg(REG_OBJ_SIZE, obj_size);
			idle_pct = (phase == 3) ? 0 : 20;
			repeat (100)
				send_count(random_count());
		end
		idle_pct = 20;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.bytes_produced = '0;
		result_ch.ready = 1'b0;
		model_cfg.min_interval_ms = RST_MIN_MS;
		model_cfg.max_interval_ms = RST_MAX_MS;
		model_cfg.target_fill_q16 = RST_FILL;
		model_cfg.speedup_weight_q16 = RST_SPEEDUP;
		model_cfg.slowdown_weight_q16 = RST_SLOWDOWN;
		model_cfg.max_object_size_bytes = RST_OBJ_SIZE;
		model_current = RST_MIN_MS;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_weight_and_fill_limits();
		test_zero_object_size();
		test_clamp_bounds();
		test_random_rounds();
		wait_idle();
		repeat (70) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("testbench NOT OK");
		$finish;
	end
endmodule
